// ===== sv/nbfb_pkg.sv =====
package nbfb_pkg;

	localparam int POINTS_DEF = 64;
	localparam int DIM_DEF = 2;

	localparam logic [1:0] ORDER_RESET = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_MISS = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

	localparam int RF_N = 25;
	localparam int MEM_W = 7 * 32;

	localparam logic [4:0] RF_P = 5'd0;
	localparam logic [4:0] RF_F0 = 5'd1;
	localparam logic [4:0] RF_F1 = 5'd2;
	localparam logic [4:0] RF_S00 = 5'd3;
	localparam logic [4:0] RF_S01 = 5'd4;
	localparam logic [4:0] RF_S10 = 5'd5;
	localparam logic [4:0] RF_S11 = 5'd6;
	localparam logic [4:0] RF_W = 5'd7;
	localparam logic [4:0] RF_R = 5'd8;
	localparam logic [4:0] RF_DQ0 = 5'd9;
	localparam logic [4:0] RF_DQ1 = 5'd10;
	localparam logic [4:0] RF_QT00 = 5'd11;
	localparam logic [4:0] RF_QT01 = 5'd12;
	localparam logic [4:0] RF_QT10 = 5'd13;
	localparam logic [4:0] RF_QT11 = 5'd14;
	localparam logic [4:0] RF_R2 = 5'd15;
	localparam logic [4:0] RF_TWOR = 5'd16;
	localparam logic [4:0] RF_T0 = 5'd17;
	localparam logic [4:0] RF_O0 = 5'd18;
	localparam logic [4:0] RF_O1 = 5'd19;
	localparam logic [4:0] RF_O2 = 5'd20;
	localparam logic [4:0] RF_O3 = 5'd21;
	localparam logic [4:0] RF_O4 = 5'd22;
	localparam logic [4:0] RF_O5 = 5'd23;
	localparam logic [4:0] RF_O6 = 5'd24;

	typedef struct packed {
		logic        command;
		logic [5:0]  point_index;
		logic [31:0] value_in;
		logic [31:0] first_0;
		logic [31:0] first_1;
		logic [31:0] second_00;
		logic [31:0] second_01;
		logic [31:0] second_10;
		logic [31:0] second_11;
		logic [31:0] weight;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [31:0] grad_0;
		logic [31:0] grad_1;
		logic [31:0] hess_00;
		logic [31:0] hess_01;
		logic [31:0] hess_10;
		logic [31:0] hess_11;
	} out_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [5:0]       idx;
		logic [7:0][31:0] dat;
	} qent_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [31:0] r;
		logic [31:0] two_r;
	} div_res_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] v;
	} fx_t;

	typedef struct packed {
		logic [4:0] a;
		logic [4:0] b;
		logic       neg;
		logic       put;
		logic [4:0] dst;
		logic [2:0] grp;
		logic       last;
	} step_t;

	function automatic fx_t fmul(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] p;
		logic [47:0]        q;
		fx_t                r;
		p = a * b + 64'sd32768;
		q = p[63:16];
		r.sat = !((&q[47:31]) || !(|q[47:31]));
		r.v = r.sat ? (q[47] ? FX_MIN : FX_MAX) : q[31:0];
		return r;
	endfunction

	function automatic fx_t sat35(input logic [34:0] s);
		fx_t r;
		r.sat = !((&s[34:31]) || !(|s[34:31]));
		r.v = r.sat ? (s[34] ? FX_MIN : FX_MAX) : s[31:0];
		return r;
	endfunction

	function automatic step_t mk(input logic [4:0] a, input logic [4:0] b, input logic neg,
			input logic put, input logic [4:0] dst, input logic [2:0] grp, input logic last);
		step_t s;
		s.a = a;
		s.b = b;
		s.neg = neg;
		s.put = put;
		s.dst = dst;
		s.grp = grp;
		s.last = last;
		return s;
	endfunction

	function automatic step_t step_info(input logic load, input logic [4:0] step);
		step_t s;
		s = mk(RF_P, RF_P, 1'b0, 1'b0, RF_T0, 3'd0, 1'b1);
		if (load) begin
			unique case (step)
				5'd0: s = mk(RF_R, RF_R, 1'b0, 1'b1, RF_R2, 3'd0, 1'b0);
				5'd1: s = mk(RF_R2, RF_F0, 1'b0, 1'b1, RF_DQ0, 3'd0, 1'b0);
				5'd2: s = mk(RF_R2, RF_F1, 1'b0, 1'b1, RF_DQ1, 3'd0, 1'b0);
				5'd3: s = mk(RF_DQ0, RF_F0, 1'b0, 1'b1, RF_T0, 3'd0, 1'b0);
				5'd4: s = mk(RF_T0, RF_TWOR, 1'b0, 1'b0, RF_T0, 3'd0, 1'b0);
				5'd5: s = mk(RF_S00, RF_R2, 1'b1, 1'b1, RF_QT00, 3'd0, 1'b0);
				5'd6: s = mk(RF_DQ0, RF_F1, 1'b0, 1'b1, RF_T0, 3'd0, 1'b0);
				5'd7: s = mk(RF_T0, RF_TWOR, 1'b0, 1'b0, RF_T0, 3'd0, 1'b0);
				5'd8: s = mk(RF_S01, RF_R2, 1'b1, 1'b1, RF_QT01, 3'd0, 1'b0);
				5'd9: s = mk(RF_DQ1, RF_F0, 1'b0, 1'b1, RF_T0, 3'd0, 1'b0);
				5'd10: s = mk(RF_T0, RF_TWOR, 1'b0, 1'b0, RF_T0, 3'd0, 1'b0);
				5'd11: s = mk(RF_S10, RF_R2, 1'b1, 1'b1, RF_QT10, 3'd0, 1'b0);
				5'd12: s = mk(RF_DQ1, RF_F1, 1'b0, 1'b1, RF_T0, 3'd0, 1'b0);
				5'd13: s = mk(RF_T0, RF_TWOR, 1'b0, 1'b0, RF_T0, 3'd0, 1'b0);
				5'd14: s = mk(RF_S11, RF_R2, 1'b1, 1'b1, RF_QT11, 3'd0, 1'b1);
				default: s = mk(RF_P, RF_P, 1'b0, 1'b0, RF_T0, 3'd0, 1'b1);
			endcase
		end else begin
			unique case (step)
				5'd0: s = mk(RF_P, RF_R, 1'b0, 1'b1, RF_T0, 3'd0, 1'b0);
				5'd1: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O0, 3'd0, 1'b0);
				5'd2: s = mk(RF_F0, RF_R, 1'b0, 1'b0, RF_T0, 3'd1, 1'b0);
				5'd3: s = mk(RF_P, RF_DQ0, 1'b1, 1'b1, RF_T0, 3'd1, 1'b0);
				5'd4: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O1, 3'd1, 1'b0);
				5'd5: s = mk(RF_F1, RF_R, 1'b0, 1'b0, RF_T0, 3'd2, 1'b0);
				5'd6: s = mk(RF_P, RF_DQ1, 1'b1, 1'b1, RF_T0, 3'd2, 1'b0);
				5'd7: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O2, 3'd2, 1'b0);
				5'd8: s = mk(RF_S00, RF_R, 1'b0, 1'b0, RF_T0, 3'd3, 1'b0);
				5'd9: s = mk(RF_F0, RF_DQ0, 1'b1, 1'b0, RF_T0, 3'd3, 1'b0);
				5'd10: s = mk(RF_F0, RF_DQ0, 1'b1, 1'b0, RF_T0, 3'd3, 1'b0);
				5'd11: s = mk(RF_P, RF_QT00, 1'b0, 1'b1, RF_T0, 3'd3, 1'b0);
				5'd12: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O3, 3'd3, 1'b0);
				5'd13: s = mk(RF_S01, RF_R, 1'b0, 1'b0, RF_T0, 3'd4, 1'b0);
				5'd14: s = mk(RF_F0, RF_DQ1, 1'b1, 1'b0, RF_T0, 3'd4, 1'b0);
				5'd15: s = mk(RF_F1, RF_DQ0, 1'b1, 1'b0, RF_T0, 3'd4, 1'b0);
				5'd16: s = mk(RF_P, RF_QT01, 1'b0, 1'b1, RF_T0, 3'd4, 1'b0);
				5'd17: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O4, 3'd4, 1'b0);
				5'd18: s = mk(RF_S10, RF_R, 1'b0, 1'b0, RF_T0, 3'd5, 1'b0);
				5'd19: s = mk(RF_F1, RF_DQ0, 1'b1, 1'b0, RF_T0, 3'd5, 1'b0);
				5'd20: s = mk(RF_F0, RF_DQ1, 1'b1, 1'b0, RF_T0, 3'd5, 1'b0);
				5'd21: s = mk(RF_P, RF_QT10, 1'b0, 1'b1, RF_T0, 3'd5, 1'b0);
				5'd22: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O5, 3'd5, 1'b0);
				5'd23: s = mk(RF_S11, RF_R, 1'b0, 1'b0, RF_T0, 3'd6, 1'b0);
				5'd24: s = mk(RF_F1, RF_DQ1, 1'b1, 1'b0, RF_T0, 3'd6, 1'b0);
				5'd25: s = mk(RF_F1, RF_DQ1, 1'b1, 1'b0, RF_T0, 3'd6, 1'b0);
				5'd26: s = mk(RF_P, RF_QT11, 1'b0, 1'b1, RF_T0, 3'd6, 1'b0);
				5'd27: s = mk(RF_T0, RF_W, 1'b0, 1'b1, RF_O6, 3'd6, 1'b1);
				default: s = mk(RF_P, RF_P, 1'b0, 1'b0, RF_T0, 3'd0, 1'b1);
			endcase
		end
		return s;
	endfunction

endpackage

// ===== sv/nbfb_ram.sv =====
module nbfb_ram
	#(
		parameter int W = 32,
		parameter int D = 64
	)
	(
		input  logic                               clk,
		input  logic                               we,
		input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
		input  logic [W-1:0]                       wdata,
		input  logic                               re,
		input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
		output logic [W-1:0]                       rdata
	);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/nbfb_div.sv =====
module nbfb_div
	import nbfb_pkg::*;
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        start,
		input  logic [30:0] den,
		output div_res_t    res
	);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [30:0] den_q;
	logic [30:0] rem_q;
	logic [32:0] num_q;
	logic [32:0] quo_q;
	logic [31:0] rem_sh;
	logic        ge;
	logic [31:0] rem_nx;
	logic        big;
	logic [31:0] r;

	always_comb begin
		rem_sh = {rem_q, num_q[32]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		big = |quo_q[32:31];
		r = big ? FX_MAX : quo_q[31:0];
		res.done = done_q;
		res.r = r;
		res.two_r = r[30] ? FX_MAX : {r[30:0], 1'b0};
		res.sat = big || r[30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 6'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			num_q <= {1'b1, 2'b00, den[30:1]};
		end else if (busy_q) begin
			rem_q <= rem_nx[30:0];
			quo_q <= {quo_q[31:0], ge};
			num_q <= {num_q[31:0], 1'b0};
		end
	end

endmodule

// ===== sv/nbfb_front.sv =====
module nbfb_front
	import nbfb_pkg::*;
	#(
		parameter int POINTS = POINTS_DEF,
		parameter int DIM = DIM_DEF
	)
	(
		input  logic  clk,
		input  logic  arst_n,
		input  logic  in_valid,
		output logic  in_stall,
		input  in_t   in_data,
		input  logic  pop,
		output logic  head_valid,
		output qent_t head
	);

	qent_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       take;
	logic       push;
	logic       inr;
	qent_t      cls;

	always_comb begin
		inr = 32'(in_data.point_index) < POINTS;
		cls.idx = in_data.point_index;
		cls.dat[0] = in_data.value_in;
		cls.dat[1] = in_data.first_0;
		cls.dat[2] = (DIM > 1) ? in_data.first_1 : 32'd0;
		cls.dat[3] = in_data.second_00;
		cls.dat[4] = (DIM > 1) ? in_data.second_01 : 32'd0;
		cls.dat[5] = (DIM > 1) ? in_data.second_10 : 32'd0;
		cls.dat[6] = (DIM > 1) ? in_data.second_11 : 32'd0;
		cls.dat[7] = in_data.weight;
		push = 1'b1;
		if (in_data.command == CMD_EVAL) begin
			cls.op = inr ? OP_EVAL : OP_MISS;
		end else begin
			push = inr;
			cls.op = ($signed(in_data.value_in) > 32'sd0) ? OP_LOAD : OP_CLEAR;
		end
	end

	assign in_stall = cnt_q == 2'd2;
	assign take = in_valid && !in_stall && push;
	assign head_valid = cnt_q != 2'd0;
	assign head = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (take && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q[wp_q] <= cls;
		end
	end

endmodule

// ===== sv/nbfb_back.sv =====
module nbfb_back
	import nbfb_pkg::*;
	#(
		parameter int POINTS = POINTS_DEF,
		parameter int DIM = DIM_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic [1:0] order,
		input  logic       head_valid,
		input  qent_t      head,
		output logic       pop,
		output logic       out_valid,
		input  logic       out_stall,
		output out_t       out_data
	);

	localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_RUN = 3'd3;
	localparam logic [2:0] S_WR = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0]         state_q;
	logic [4:0]         step_q;
	logic               sat_q;
	logic               miss_q;
	logic               out_valid_q;
	logic [POINTS-1:0]  loaded_q;
	logic [POINTS-1:0]  lsat_q;
	logic [1:0]         op_q;
	logic [AW-1:0]      addr_q;
	logic signed [31:0] rf_q [RF_N];
	logic [34:0]        acc_q;
	out_t               out_q;

	logic [1:0]         ord;
	logic [6:0]         act;
	step_t              st;
	fx_t                fm;
	logic [34:0]        m35;
	logic [34:0]        sum;
	fx_t                sr;
	logic               hit;
	logic               fin_go;
	logic               div_start;
	div_res_t           dres;
	logic               ram_we;
	logic               ram_re;
	logic [MEM_W-1:0]   ram_wdata;
	logic [MEM_W-1:0]   ram_rdata;
	logic [AW-1:0]      head_addr;

	nbfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (head.dat[0][30:0]),
		.res    (dres)
	);

	nbfb_ram #(
		.W (MEM_W),
		.D (POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ord = (order == 2'd3) ? 2'd2 : order;
		act[0] = 1'b1;
		act[1] = ord >= 2'd1;
		act[2] = (ord >= 2'd1) && (DIM > 1);
		act[3] = ord >= 2'd2;
		act[4] = (ord >= 2'd2) && (DIM > 1);
		act[5] = (ord >= 2'd2) && (DIM > 1);
		act[6] = (ord >= 2'd2) && (DIM > 1);
		st = step_info(op_q == OP_LOAD, step_q);
		fm = fmul(rf_q[st.a], rf_q[st.b]);
		m35 = {{3{fm.v[31]}}, fm.v};
		sum = st.neg ? (acc_q - m35) : (acc_q + m35);
		sr = sat35(sum);
		hit = act[st.grp] && (fm.sat || (st.put && sr.sat));
		pop = (state_q == S_IDLE) && head_valid;
		head_addr = AW'(head.idx);
		div_start = pop && (head.op == OP_LOAD);
		ram_re = pop && (head.op == OP_EVAL);
		ram_we = state_q == S_WR;
		ram_wdata = {rf_q[RF_R], rf_q[RF_DQ0], rf_q[RF_DQ1], rf_q[RF_QT00],
			rf_q[RF_QT01], rf_q[RF_QT10], rf_q[RF_QT11]};
		fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			sat_q <= 1'b0;
			miss_q <= 1'b0;
			out_valid_q <= 1'b0;
			loaded_q <= '0;
			lsat_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						step_q <= '0;
						miss_q <= (head.op == OP_MISS);
						unique case (head.op)
							OP_LOAD: state_q <= S_DIV;
							OP_CLEAR: loaded_q[head_addr] <= 1'b0;
							OP_EVAL: state_q <= S_RD;
							OP_MISS: state_q <= S_FIN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: begin
					sat_q <= lsat_q[addr_q];
					if (loaded_q[addr_q]) begin
						state_q <= S_RUN;
					end else begin
						miss_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					if (dres.done) begin
						sat_q <= dres.sat;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					sat_q <= sat_q || hit;
					step_q <= step_q + 5'd1;
					if (st.last) begin
						state_q <= (op_q == OP_LOAD) ? S_WR : S_FIN;
					end
				end
				S_WR: begin
					loaded_q[addr_q] <= 1'b1;
					lsat_q[addr_q] <= sat_q;
					state_q <= S_IDLE;
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head.op;
			addr_q <= head_addr;
			acc_q <= '0;
			for (int k = 0; k < 8; k++) begin
				rf_q[k] <= head.dat[k];
			end
		end
		if (state_q == S_RD) begin
			rf_q[RF_R] <= ram_rdata[223:192];
			rf_q[RF_DQ0] <= ram_rdata[191:160];
			rf_q[RF_DQ1] <= ram_rdata[159:128];
			rf_q[RF_QT00] <= ram_rdata[127:96];
			rf_q[RF_QT01] <= ram_rdata[95:64];
			rf_q[RF_QT10] <= ram_rdata[63:32];
			rf_q[RF_QT11] <= ram_rdata[31:0];
		end
		if ((state_q == S_DIV) && dres.done) begin
			rf_q[RF_R] <= dres.r;
			rf_q[RF_TWOR] <= dres.two_r;
		end
		if (state_q == S_RUN) begin
			if (st.put) begin
				rf_q[st.dst] <= sr.v;
				acc_q <= '0;
			end else begin
				acc_q <= sum;
			end
		end
		if (fin_go) begin
			out_q.status <= miss_q ? ST_MISS : (sat_q ? ST_SAT : ST_OK);
			out_q.value_out <= miss_q ? 32'd0 : rf_q[RF_O0];
			out_q.grad_0 <= (miss_q || !act[1]) ? 32'd0 : rf_q[RF_O1];
			out_q.grad_1 <= (miss_q || !act[2]) ? 32'd0 : rf_q[RF_O2];
			out_q.hess_00 <= (miss_q || !act[3]) ? 32'd0 : rf_q[RF_O3];
			out_q.hess_01 <= (miss_q || !act[4]) ? 32'd0 : rf_q[RF_O4];
			out_q.hess_10 <= (miss_q || !act[5]) ? 32'd0 : rf_q[RF_O5];
			out_q.hess_11 <= (miss_q || !act[6]) ? 32'd0 : rf_q[RF_O6];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== sv/nurbs_basis_from_bspline_top.sv =====
// Converts B-spline basis data to rational basis data for one point at a time.
// The input channel (in_valid, in_stall, in_data) carries load and evaluate
// items; a load with a positive value stores the weight function terms of one
// point and any other load clears its loaded mark, neither giving a result;
// an evaluate gives exactly one result on out_valid, out_stall and out_data.
// A transfer happens on a rising edge with valid high and stall low. Items
// pass a two-entry queue to a sequencer that owns one 32 by 32 multiplier, so
// an evaluate of a loaded point runs 28 multiply steps before the output
// register, and a storing load runs the bit-serial reciprocal and then 15
// multiply steps. The sequencer takes the next item only once it is idle
// again; the queue takes up to two more items while the sequencer works.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its next result until that transfer completes.
// Reset clears the queue, the output valid flag and all loaded marks, and sets
// the derivative order to two. The order register is written through cfg_we.
module nurbs_basis_from_bspline_top
	import nbfb_pkg::*;
	#(
		parameter int POINTS = POINTS_DEF,
		parameter int DIM = DIM_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       in_valid,
		output logic       in_stall,
		input  in_t        in_data,
		output logic       out_valid,
		input  logic       out_stall,
		output out_t       out_data,
		input  logic       cfg_we,
		input  logic [1:0] cfg_data
	);

	logic [1:0] order_q;
	logic       head_valid;
	qent_t      head;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_we) begin
			order_q <= cfg_data;
		end
	end

	nbfb_front #(
		.POINTS (POINTS),
		.DIM    (DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nbfb_back #(
		.POINTS (POINTS),
		.DIM    (DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.order      (order_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import nbfb_pkg::*;

	localparam longint FXMAX = 64'sd2147483647;
	localparam longint FXMIN = -64'sd2147483648;
	localparam int QUIET = 200;

	class rational_scoreboard;
		logic [31:0] recip[64];
		logic [31:0] dqo0[64];
		logic [31:0] dqo1[64];
		logic [31:0] qt[64][4];
		bit loaded[64];
		bit load_sat[64];
		logic [1:0] order;
		bit sat_flag;
		out_t pending[$];
		int mismatches;

		function new();
			foreach (loaded[i]) begin
				loaded[i] = 0;
				load_sat[i] = 0;
			end
			order = ORDER_RESET;
			mismatches = 0;
		endfunction

		function longint clip(longint v);
			if (v > FXMAX) begin
				sat_flag = 1;
				return FXMAX;
			end
			if (v < FXMIN) begin
				sat_flag = 1;
				return FXMIN;
			end
			return v;
		endfunction

		function longint qmul(longint a, longint b);
			longint p;
			p = a * b + 32768;
			return clip(p >>> 16);
		endfunction

		function void note_item(in_t it);
			longint q, r, r2, tr;
			longint dq[2], d2q[2][2], dq2[2], p, dp[2], d2p[2][2], w, rr, dd[2], tt[2][2];
			out_t o;
			int idx;
			idx = int'(it.point_index);
			if (it.command == CMD_LOAD) begin
				q = $signed(it.value_in);
				if (q <= 0) begin
					loaded[idx] = 0;
					return;
				end
				sat_flag = 0;
				dq[0] = $signed(it.first_0);
				dq[1] = $signed(it.first_1);
				d2q[0][0] = $signed(it.second_00);
				d2q[0][1] = $signed(it.second_01);
				d2q[1][0] = $signed(it.second_10);
				d2q[1][1] = $signed(it.second_11);
				r = clip((64'sd4294967296 + q / 2) / q);
				r2 = qmul(r, r);
				tr = clip(2 * r);
				for (int i = 0; i < 2; i++)
					dq2[i] = qmul(r2, dq[i]);
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++)
						qt[idx][2 * i + j] = 32'(clip(qmul(qmul(dq2[i], dq[j]), tr)
							- qmul(d2q[i][j], r2)));
				recip[idx] = 32'(r);
				dqo0[idx] = 32'(dq2[0]);
				dqo1[idx] = 32'(dq2[1]);
				load_sat[idx] = sat_flag;
				loaded[idx] = 1;
				return;
			end
			o = '0;
			if (!loaded[idx]) begin
				o.status = ST_MISS;
				pending.push_back(o);
				return;
			end
			sat_flag = 0;
			p = $signed(it.value_in);
			dp[0] = $signed(it.first_0);
			dp[1] = $signed(it.first_1);
			d2p[0][0] = $signed(it.second_00);
			d2p[0][1] = $signed(it.second_01);
			d2p[1][0] = $signed(it.second_10);
			d2p[1][1] = $signed(it.second_11);
			w = $signed(it.weight);
			rr = $signed(recip[idx]);
			dd[0] = $signed(dqo0[idx]);
			dd[1] = $signed(dqo1[idx]);
			for (int k = 0; k < 4; k++)
				tt[k / 2][k % 2] = $signed(qt[idx][k]);
			o.value_out = 32'(qmul(qmul(p, rr), w));
			if (order >= 1) begin
				o.grad_0 = 32'(qmul(clip(qmul(dp[0], rr) - qmul(p, dd[0])), w));
				o.grad_1 = 32'(qmul(clip(qmul(dp[1], rr) - qmul(p, dd[1])), w));
			end
			if (order >= 2) begin
				logic [31:0] h[4];
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++)
						h[2 * i + j] = 32'(qmul(clip(qmul(d2p[i][j], rr)
							- qmul(dp[i], dd[j]) - qmul(dp[j], dd[i])
							+ qmul(p, tt[i][j])), w));
				o.hess_00 = h[0];
				o.hess_01 = h[1];
				o.hess_10 = h[2];
				o.hess_11 = h[3];
			end
			o.status = (sat_flag || load_sat[idx]) ? ST_SAT : ST_OK;
			pending.push_back(o);
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer: %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %h, got %h", exp_r, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_data;

	rational_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	nurbs_basis_from_bspline_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_item(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(131072) - 65536;
			3: return $urandom_range(8192) - 4096;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic in_t make_item(logic cmd, logic [5:0] idx);
		in_t it;
		it.command = cmd;
		it.point_index = idx;
		it.value_in = rand_field();
		it.first_0 = rand_field();
		it.first_1 = rand_field();
		it.second_00 = rand_field();
		it.second_01 = rand_field();
		it.second_10 = rand_field();
		it.second_11 = rand_field();
		it.weight = rand_field();
		if (cmd == CMD_LOAD && $urandom_range(3) != 0)
			it.value_in = $urandom_range(32'h0004_0000, 32'h0000_4000);
		return it;
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	task automatic write_order(logic [1:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.order = (v > 2'd2) ? 2'd2 : v;
	endtask

	task automatic run_random(int n);
		in_t it;
		logic [5:0] idx;
		for (int k = 0; k < n; k++) begin
			idx = 6'($urandom_range(63));
			if ($urandom_range(3) == 0)
				it = make_item(CMD_LOAD, idx);
			else
				it = make_item(CMD_EVAL, idx);
			send_item(it);
		end
	endtask

	initial begin
		in_t it;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_item(make_item(CMD_EVAL, 6'd5));
		it = make_item(CMD_LOAD, 6'd0);
		it.value_in = 32'h0001_0000;
		send_item(it);
		it = make_item(CMD_EVAL, 6'd0);
		it.value_in = 32'h7FFF_FFFF;
		it.weight = 32'h8000_0000;
		send_item(it);
		it = make_item(CMD_LOAD, 6'd63);
		it.value_in = 32'h0000_0001;
		send_item(it);
		send_item(make_item(CMD_EVAL, 6'd63));
		it = make_item(CMD_LOAD, 6'd1);
		it.value_in = 32'h7FFF_FFFF;
		send_item(it);
		send_item(make_item(CMD_EVAL, 6'd1));
		it = make_item(CMD_LOAD, 6'd1);
		it.value_in = 32'h0000_0000;
		send_item(it);
		send_item(make_item(CMD_EVAL, 6'd1));
		it = make_item(CMD_LOAD, 6'd2);
		it.value_in = 32'h8000_0000;
		send_item(it);
		send_item(make_item(CMD_EVAL, 6'd2));
		it = '0;
		it.command = CMD_EVAL;
		send_item(it);
		it = '1;
		it.command = CMD_EVAL;
		it.point_index = 6'd0;
		send_item(it);

		write_order(2'd0);
		run_random(80);
		write_order(2'd1);
		send_idle_pct = 75;
		run_random(80);
		write_order(2'd3);
		send_idle_pct = 0;
		recv_stall_pct = 75;
		run_random(200);
		write_order(2'd2);
		recv_stall_pct = 7;
		send_idle_pct = 7;
		run_random(250);
		hold_cycles = 400;
		recv_stall_pct = 0;
		send_idle_pct = 0;
		run_random(40);
		drain();
		run_random(300);
		send_idle_pct = 75;
		recv_stall_pct = 75;
		run_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(150);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
